### src/qrs_pkg.sv
`timescale 1ns / 1ps
// shared status codes and status field width for the quadratic root solver
package qrs_pkg;

  localparam int unsigned StatusW = 2;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_LEAD_ZERO = 2'd1;
  localparam logic [StatusW-1:0] ST_NO_REAL   = 2'd2;

endpackage

### src/quadratic_root_solver.sv
`timescale 1ns / 1ps
// quadratic root solver: discriminant, pipelined square root, two pipelined dividers
// throughput one request per cycle unless a result waits at the output; that stall holds
// every stage; depth set by one square root bit and one quotient bit per stage over
// COEF_WIDTH+1 root bits and COEF_WIDTH+FRAC_BITS+2 quotient bits
// a one-entry input skid takes one more request while a result waits at the output
// reset (rst_ni low, asynchronous) empties every stage; no clearing pass is needed
module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // coef_a, coef_b, coef_c, zero fill
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // root_plus, root_minus, zero fill
  output logic [((2*COEF_WIDTH+7)/8)*8-1:0]      m_axis_tdata_o,
  // status, double_root, overflow
  output logic [qrs_pkg::StatusW+1:0]            m_axis_tuser_o
);

  localparam int unsigned W    = COEF_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned IDW  = ((3*W+7)/8)*8;
  localparam int unsigned ODW  = ((2*W+7)/8)*8;
  localparam int unsigned DW   = 2*W+2;
  localparam int unsigned SW   = W+1;
  localparam int unsigned NW   = W+2;
  localparam int unsigned QW   = NW+F;
  localparam int unsigned DNW  = W+1;
  localparam int unsigned STW  = qrs_pkg::StatusW;

  typedef struct packed {
    logic [W-1:0]   am;
    logic [W-1:0]   bm;
    logic           a_neg;
    logic           b_neg;
    logic [STW-1:0] st;
    logic           dz;
  } sq_side_t;

  typedef struct packed {
    logic [DNW-1:0] den;
    logic           neg_p;
    logic           neg_m;
    logic [STW-1:0] st;
    logic           dz;
  } dv_side_t;

  logic en;
  logic out_v_q;
  assign en = !out_v_q || m_axis_tready_i;

  // input skid
  logic           sk_v_q;
  logic [3*W-1:0] sk_data_q;
  logic           in_v;
  logic [3*W-1:0] in_data;

  assign s_axis_tready_o = !sk_v_q;
  assign in_v    = sk_v_q || s_axis_tvalid_i;
  assign in_data = sk_v_q ? sk_data_q : s_axis_tdata_i[3*W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_v_q <= 1'b0;
    end else if (en) begin
      sk_v_q <= 1'b0;
    end else if (s_axis_tvalid_i && !sk_v_q) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && s_axis_tvalid_i && !sk_v_q) begin
      sk_data_q <= s_axis_tdata_i[3*W-1:0];
    end
  end

  // stage a: magnitudes and signs
  logic [W-1:0] a_raw, b_raw, c_raw;
  logic         a_v_q;
  logic [W-1:0] a_am_q, a_bm_q, a_cm_q;
  logic         a_an_q, a_bn_q, a_cn_q;

  assign a_raw = in_data[W-1:0];
  assign b_raw = in_data[2*W-1:W];
  assign c_raw = in_data[3*W-1:2*W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_an_q <= a_raw[W-1];
      a_bn_q <= b_raw[W-1];
      a_cn_q <= c_raw[W-1];
      a_am_q <= a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
      a_bm_q <= b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;
      a_cm_q <= c_raw[W-1] ? (~c_raw + 1'b1) : c_raw;
    end
  end

  // stage b: products
  logic           b_v_q;
  logic [2*W-1:0] b_bb_q, b_ac_q;
  logic [W-1:0]   b_am_q, b_bm_q;
  logic           b_an_q, b_bn_q, b_add_q, b_az_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_bb_q  <= a_bm_q * a_bm_q;
      b_ac_q  <= a_am_q * a_cm_q;
      b_am_q  <= a_am_q;
      b_bm_q  <= a_bm_q;
      b_an_q  <= a_an_q;
      b_bn_q  <= a_bn_q;
      b_add_q <= (a_cm_q != '0) && (a_an_q != a_cn_q);
      b_az_q  <= (a_am_q == '0);
    end
  end

  // stage c: discriminant and status
  logic [DW-1:0]  c_bb, c_ac4, c_d;
  logic           c_lt;
  logic [STW-1:0] c_st;

  assign c_bb  = DW'(b_bb_q);
  assign c_ac4 = DW'(b_ac_q) << 2;
  assign c_lt  = !b_add_q && (c_bb < c_ac4);
  assign c_d   = b_add_q ? (c_bb + c_ac4) : (c_bb - c_ac4);

  always_comb begin
    if (b_az_q) begin
      c_st = qrs_pkg::ST_LEAD_ZERO;
    end else if (c_lt) begin
      c_st = qrs_pkg::ST_NO_REAL;
    end else begin
      c_st = qrs_pkg::ST_OK;
    end
  end

  // square root pipeline, one root bit per stage
  logic           sq_v_q    [0:SW];
  logic [SW:0]    sq_rem_q  [0:SW];
  logic [SW-1:0]  sq_root_q [0:SW];
  logic [DW-1:0]  sq_rad_q  [0:SW];
  sq_side_t       sq_side_q [0:SW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]        <= '0;
      sq_root_q[0]       <= '0;
      sq_rad_q[0]        <= c_d;
      sq_side_q[0].am    <= b_am_q;
      sq_side_q[0].bm    <= b_bm_q;
      sq_side_q[0].a_neg <= b_an_q;
      sq_side_q[0].b_neg <= b_bn_q;
      sq_side_q[0].st    <= c_st;
      sq_side_q[0].dz    <= (c_d == '0);
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_sq
    logic [SW+2:0] t;
    logic [SW+2:0] trial;
    logic [SW+2:0] diff;
    logic          ge;

    assign t     = {sq_rem_q[k], sq_rad_q[k][DW-1 -: 2]};
    assign trial = {1'b0, sq_root_q[k], 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k+1]  <= ge ? diff[SW:0] : t[SW:0];
        sq_root_q[k+1] <= {sq_root_q[k][SW-2:0], ge};
        sq_rad_q[k+1]  <= {sq_rad_q[k][DW-3:0], 2'b00};
        sq_side_q[k+1] <= sq_side_q[k];
      end
    end
  end

  // stage e: numerators and denominator
  sq_side_t        e_sd;
  logic signed [W+2:0] e_nb, e_s, e_np, e_nm;
  logic [W+2:0]    e_npa, e_nma;

  assign e_sd  = sq_side_q[SW];
  assign e_nb  = e_sd.b_neg ? $signed({3'b000, e_sd.bm}) : -$signed({3'b000, e_sd.bm});
  assign e_s   = $signed({2'b00, sq_root_q[SW]});
  assign e_np  = e_nb + e_s;
  assign e_nm  = e_nb - e_s;
  assign e_npa = e_np[W+2] ? (~e_np + 1'b1) : e_np;
  assign e_nma = e_nm[W+2] ? (~e_nm + 1'b1) : e_nm;

  logic           dv_v_q    [0:QW];
  logic [DNW-1:0] dvp_rem_q [0:QW];
  logic [QW-1:0]  dvp_num_q [0:QW];
  logic [DNW-1:0] dvm_rem_q [0:QW];
  logic [QW-1:0]  dvm_num_q [0:QW];
  dv_side_t       dv_side_q [0:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvp_rem_q[0]       <= '0;
      dvm_rem_q[0]       <= '0;
      dvp_num_q[0]       <= QW'(e_npa[NW-1:0]) << F;
      dvm_num_q[0]       <= QW'(e_nma[NW-1:0]) << F;
      dv_side_q[0].den   <= {e_sd.am, 1'b0};
      dv_side_q[0].neg_p <= e_np[W+2] != e_sd.a_neg;
      dv_side_q[0].neg_m <= e_nm[W+2] != e_sd.a_neg;
      dv_side_q[0].st    <= e_sd.st;
      dv_side_q[0].dz    <= e_sd.dz;
    end
  end

  // two dividers, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_dv
    logic [DNW:0] tp, tm, dp, dm, den;
    logic         gep, gem;

    assign den = {1'b0, dv_side_q[k].den};
    assign tp  = {dvp_rem_q[k], dvp_num_q[k][QW-1]};
    assign tm  = {dvm_rem_q[k], dvm_num_q[k][QW-1]};
    assign gep = tp >= den;
    assign gem = tm >= den;
    assign dp  = tp - den;
    assign dm  = tm - den;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dvp_rem_q[k+1] <= gep ? dp[DNW-1:0] : tp[DNW-1:0];
        dvm_rem_q[k+1] <= gem ? dm[DNW-1:0] : tm[DNW-1:0];
        dvp_num_q[k+1] <= {dvp_num_q[k][QW-2:0], gep};
        dvm_num_q[k+1] <= {dvm_num_q[k][QW-2:0], gem};
        dv_side_q[k+1] <= dv_side_q[k];
      end
    end
  end

  // saturation and output register
  function automatic logic [W:0] sat_root(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] half;
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    logic          ovf;
    logic [W-1:0]  m;
    half = QW'(1) << (W-1);
    lim  = neg ? half : (half - 1'b1);
    ovf  = q > lim;
    mag  = ovf ? lim : q;
    m    = mag[W-1:0];
    return {ovf, neg ? (~m + 1'b1) : m};
  endfunction

  dv_side_t       f_sd;
  logic [W:0]     f_p, f_m;
  logic           f_ok;
  logic [W-1:0]   out_p_q, out_m_q;
  logic [STW-1:0] out_st_q;
  logic           out_dz_q, out_ovf_q;

  assign f_sd = dv_side_q[QW];
  assign f_p  = sat_root(dvp_num_q[QW], f_sd.neg_p);
  assign f_m  = sat_root(dvm_num_q[QW], f_sd.neg_m);
  assign f_ok = f_sd.st == qrs_pkg::ST_OK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_p_q   <= f_ok ? f_p[W-1:0] : '0;
      out_m_q   <= f_ok ? f_m[W-1:0] : '0;
      out_st_q  <= f_sd.st;
      out_dz_q  <= f_ok && f_sd.dz;
      out_ovf_q <= f_ok && (f_p[W] || f_m[W]);
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = ODW'({out_m_q, out_p_q});
  assign m_axis_tuser_o  = {out_ovf_q, out_dz_q, out_st_q};

  logic unused_pad;
  assign unused_pad = ^s_axis_tdata_i[IDW-1:3*W-1];

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the quadratic root solver stream pipeline
module tb_top;

  localparam int unsigned CW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned Latency = 2*CW + FB + 8;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [CW-1:0] c;
    logic [CW-1:0] b;
    logic [CW-1:0] a;
  } coef_t;

  typedef struct packed {
    logic                        overflow;
    logic                        double_root;
    logic [qrs_pkg::StatusW-1:0] status;
    logic [CW-1:0]               root_minus;
    logic [CW-1:0]               root_plus;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  coef_t s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [2*CW-1:0] m_data;
  logic [qrs_pkg::StatusW+1:0] m_user;

  coef_t pending_coefs[$];
  roots_t expected_roots[$];
  logic req_taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned requests_taken = 0;
  int unsigned idle_cycles = 0;
  bit hold_done = 1'b0;

  quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [CW-1:0] scale_root(logic signed [63:0] num, logic a_neg,
                                               logic [63:0] den, ref logic ovf);
    logic nneg;
    logic neg;
    logic [63:0] nmag;
    logic [127:0] q;
    logic [63:0] lim;
    logic [63:0] mag;
    nneg = num < 0;
    nmag = nneg ? -num : num;
    q = ({64'd0, nmag} << FB) / {64'd0, den};
    neg = nneg ^ a_neg;
    lim = neg ? (64'd1 << (CW-1)) : (64'd1 << (CW-1)) - 1;
    if (q > {64'd0, lim}) begin
      ovf = 1'b1;
      mag = lim;
    end else begin
      mag = q[63:0];
    end
    return neg ? -mag[CW-1:0] : mag[CW-1:0];
  endfunction

  function automatic roots_t solve_quadratic(coef_t k);
    roots_t r;
    logic an, bn, cn, ovf;
    logic [63:0] am, bm, cm, s, cand;
    logic [127:0] bb, ac4, d, sq;
    logic signed [63:0] nb;
    r = '0;
    ovf = 1'b0;
    an = k.a[CW-1];
    bn = k.b[CW-1];
    cn = k.c[CW-1];
    am = an ? 64'd0 - {{32{1'b1}}, k.a} : {32'd0, k.a};
    bm = bn ? 64'd0 - {{32{1'b1}}, k.b} : {32'd0, k.b};
    cm = cn ? 64'd0 - {{32{1'b1}}, k.c} : {32'd0, k.c};
    r.status = qrs_pkg::ST_OK;
    if (am == 0) begin
      r.status = qrs_pkg::ST_LEAD_ZERO;
      return r;
    end
    bb = {64'd0, bm} * {64'd0, bm};
    ac4 = ({64'd0, am} * {64'd0, cm}) << 2;
    if (cm != 0 && an != cn) begin
      d = bb + ac4;
    end else if (bb < ac4) begin
      r.status = qrs_pkg::ST_NO_REAL;
      return r;
    end else begin
      d = bb - ac4;
    end
    s = 0;
    for (int i = 63; i >= 0; i--) begin
      cand = s | (64'd1 << i);
      sq = {64'd0, cand} * {64'd0, cand};
      if (sq <= d) s = cand;
    end
    nb = bn ? $signed(bm) : -$signed(bm);
    r.root_plus = scale_root(nb + $signed(s), an, am << 1, ovf);
    r.root_minus = scale_root(nb - $signed(s), an, am << 1, ovf);
    r.double_root = (d == 0);
    r.overflow = ovf;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CW-1:0] modest_value();
    logic [CW-1:0] v;
    v = $urandom() >> $urandom_range(8, 31);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    $display("error: %s got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // request driver
  int unsigned send_gap = 0;
  int unsigned sent = 0;
  always @(negedge clk_i) begin
    logic nv;
    coef_t nd;
    nv = s_valid;
    nd = s_data;
    if (rst_ni) begin
      if (s_valid && req_taken) nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_coefs.size() > 0) begin
          nd = pending_coefs.pop_front();
          nv = 1'b1;
          sent++;
          send_gap = ((sent / 200) % 3 == 1) ? 0 : pick_gap();
        end
      end
    end
    s_valid <= nv;
    s_data <= nd;
  end

  // result receiver, with one long hold-off
  int unsigned hold_left = 0;
  always @(negedge clk_i) begin
    logic nr;
    nr = 1'b0;
    if (rst_ni) begin
      if (!hold_done && requests_taken >= 300) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if ((requests_taken / 250) % 3 == 2) begin
        nr = 1'b1;
      end else begin
        nr = pick_gap() == 0;
      end
    end
    m_ready <= nr;
  end

  // monitor and checker
  always @(posedge clk_i) begin
    roots_t got;
    roots_t want;
    req_taken <= s_valid && s_ready;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        expected_roots.push_back(solve_quadratic(s_data));
        requests_taken++;
      end
      if (m_valid && m_ready) begin
        got = {m_user, m_data};
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected result", got.root_plus, '0);
        end else begin
          want = expected_roots.pop_front();
          if (got.root_plus !== want.root_plus)
            report_mismatch("root_plus", got.root_plus, want.root_plus);
          if (got.root_minus !== want.root_minus)
            report_mismatch("root_minus", got.root_minus, want.root_minus);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.double_root !== want.double_root)
            report_mismatch("double_root", got.double_root, want.double_root);
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
        end
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("quadratic_root_solver: mismatch");
        $finish;
      end
    end
  end

  initial begin
    coef_t k;
    logic [CW-1:0] one, maxv, minv;
    logic [CW-1:0] ra, r1, r2;
    logic signed [63:0] t;
    one = 1 << FB;
    maxv = {1'b0, {(CW-1){1'b1}}};
    minv = {1'b1, {(CW-1){1'b0}}};
    // directed: zero lead, negative disc, double root, extremes, saturation
    pending_coefs.push_back('{c: one, b: one, a: '0});
    pending_coefs.push_back('{c: '0, b: '0, a: '0});
    pending_coefs.push_back('{c: maxv, b: minv, a: '0});
    pending_coefs.push_back('{c: one, b: '0, a: one});
    pending_coefs.push_back('{c: -one, b: '0, a: -one});
    pending_coefs.push_back('{c: one, b: 2*one, a: one});
    pending_coefs.push_back('{c: '0, b: '0, a: one});
    pending_coefs.push_back('{c: -4*one, b: '0, a: one});
    pending_coefs.push_back('{c: 2*one, b: -3*one, a: one});
    pending_coefs.push_back('{c: minv, b: minv, a: minv});
    pending_coefs.push_back('{c: maxv, b: maxv, a: maxv});
    pending_coefs.push_back('{c: maxv, b: minv, a: minv});
    pending_coefs.push_back('{c: minv, b: maxv, a: maxv});
    pending_coefs.push_back('{c: '0, b: maxv, a: 1});
    pending_coefs.push_back('{c: minv, b: minv, a: 1});
    pending_coefs.push_back('{c: maxv, b: '0, a: -1});
    pending_coefs.push_back('{c: '1, b: '1, a: '1});
    pending_coefs.push_back('{c: 1, b: 2, a: 1});
    pending_coefs.push_back('{c: one, b: 3*one, a: 1});
    pending_coefs.push_back('{c: -one, b: -one, a: minv});
    for (int n = 0; n < 1450; n++) begin
      case ($urandom_range(0, 9))
        0, 1: k = '{c: $urandom(), b: $urandom(), a: $urandom()};
        2: k = '{c: $urandom(), b: $urandom(), a: '0};
        3, 4, 5: k = '{c: modest_value(), b: modest_value(), a: modest_value()};
        default: begin
          // coefficients built from two chosen roots
          ra = modest_value() >>> $urandom_range(0, 12);
          if (ra == 0) ra = one;
          r1 = $signed(modest_value()) >>> 8;
          r2 = ($urandom_range(0, 3) == 0) ? r1 : $signed(modest_value()) >>> 8;
          t = -(($signed(ra) * ($signed(r1) + $signed(r2))) >>> FB);
          k.a = ra;
          k.b = t[CW-1:0];
          t = ((($signed(ra) * $signed(r1)) >>> FB) * $signed(r2)) >>> FB;
          k.c = t[CW-1:0];
        end
      endcase
      pending_coefs.push_back(k);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_coefs.size() == 0 && !s_valid);
    wait (expected_roots.size() == 0);
    repeat (Latency + 20) @(posedge clk_i);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver: match");
    end else begin
      $display("quadratic_root_solver: mismatch");
    end
    $finish;
  end

endmodule
